// ===== sv/pfm_pkg.sv =====
package pfm_pkg;

  // Field widths of the item channels and the registers.
  localparam int unsigned ELAPSED_W = 24;
  localparam int unsigned K_W       = 16;
  localparam int unsigned TIMEOUT_W = 8;
  localparam int unsigned FLOW_W    = 16;
  localparam int unsigned VOL_W     = 32;
  localparam int unsigned PULSE_W   = 16;
  localparam int unsigned IDLE_W    = 8;
  localparam int unsigned SESSION_W = 32;

  // Divider operand widths. The flow numerator is pulses * 6e11 (16 + 40 bits),
  // the flow divisor is elapsed_us * k (24 + 16 bits).
  localparam int unsigned NUM_W  = 56;
  localparam int unsigned DEN_W  = 40;
  localparam int unsigned QUOT_W = 32;
  localparam int unsigned VNUM_W = 49;

  // 60 s * 1e6 us * 100 (centi L/min) * 100 (k in hundredths).
  localparam logic [39:0] FLOW_SCALE = 40'd600000000000;
  // 1000 mL * 100 (k in hundredths).
  localparam logic [16:0] VOL_SCALE  = 17'd100000;

  // Quotient bits produced per division. Flow saturates above 16 bits.
  localparam int unsigned STEP_W = 6;
  localparam logic [STEP_W-1:0] FLOW_STEPS = 6'd16;
  localparam logic [STEP_W-1:0] VOL_STEPS  = 6'd32;

  // Command queue between the front and back parts.
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = 2;

  localparam logic [K_W-1:0]       K_RESET       = 16'd472;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 8'd30;

  // Input opcodes.
  typedef enum logic [1:0] {
    OP_PULSE  = 2'd0,
    OP_UPDATE = 2'd1,
    OP_CLEAR  = 2'd2
  } opcode_e;

  // Register indexes of the configuration port.
  typedef enum logic {
    REG_K_FACTOR = 1'b0,
    REG_TIMEOUT  = 1'b1
  } reg_e;

  // Commands held in the queue.
  typedef enum logic [1:0] {
    CMD_PULSE  = 2'd0,
    CMD_UPDATE = 2'd1,
    CMD_CLEAR  = 2'd2
  } cmd_e;

  typedef struct packed {
    cmd_e                 cmd;
    logic [ELAPSED_W-1:0] elapsed;
  } entry_t;

  typedef struct packed {
    logic             start;
    logic             long_run;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic              ovf;
    logic [QUOT_W-1:0] quot;
  } div_res_t;

endpackage

// ===== sv/pfm_if.sv =====
interface pfm_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [23:0] elapsed_us;

  modport source (output valid, output opcode, output elapsed_us, input ready);
  modport sink   (input valid, input opcode, input elapsed_us, output ready);
endinterface

interface pfm_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] flow_centi_lpm;
  logic [31:0] volume_ml;
  logic [15:0] interval_pulses;
  logic [7:0]  idle_updates;
  logic        no_signal;

  modport source (output valid, output flow_centi_lpm, output volume_ml,
                  output interval_pulses, output idle_updates, output no_signal,
                  input ready);
  modport sink   (input valid, input flow_centi_lpm, input volume_ml,
                  input interval_pulses, input idle_updates, input no_signal,
                  output ready);
endinterface

// ===== sv/pulse_flow_meter.sv =====
// Pulse flow meter with a programmable K factor.
// Items arrive on in_ch (valid/ready): a pulse edge, a periodic update that
// carries the microseconds since the last update, or a session reset. Each
// update returns one item on out_ch with the flow in 0.01 L/min, the session
// volume in mL, the pulses of the interval, the idle update count and the
// no-signal flag. Pulse and session reset items return nothing.
// The front classifies items into a four-entry command queue; the back
// executes them in order. A pulse or session reset is handled by the back
// without leaving its idle state. An update uses the shared one-bit-per-cycle
// divider, which runs 16 steps for the flow and 32 steps for the volume; the
// flow division is skipped when the elapsed time is zero.
// The result sits in an output register, so the back keeps draining the
// queue while the receiver stalls; it waits only when a second result is
// ready before the first has been taken, and the queue then fills and
// drops in_ch.ready. Reset clears all counters, the flow, the session and
// the queue, and loads K = 4.72 pulses/L and a timeout of 30 updates.
// Registers are written through the APB port at byte 0 (K factor) and 4
// (timeout); the user must write them only while no update is in flight, as
// the block does not enforce it. A K factor write of zero is ignored.
module pulse_flow_meter (
  input  logic        clk_i,
  input  logic        rst_ni,
  pfm_in_if.sink      in_ch,
  pfm_out_if.source   out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [pfm_pkg::K_W-1:0]       k_q;
  logic [pfm_pkg::TIMEOUT_W-1:0] timeout_q;

  logic            wr_en;
  logic            q_valid;
  logic            q_pop;
  pfm_pkg::entry_t q_entry;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  // Configuration registers. Only bit 2 of the address selects a register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q       <= pfm_pkg::K_RESET;
      timeout_q <= pfm_pkg::TIMEOUT_RESET;
    end else if (wr_en) begin
      case (paddr[2])
        pfm_pkg::REG_K_FACTOR: begin
          if (pwdata[15:0] != '0) begin
            k_q <= pwdata[15:0];
          end
        end
        pfm_pkg::REG_TIMEOUT: begin
          timeout_q <= pwdata[7:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      pfm_pkg::REG_K_FACTOR: prdata = {16'd0, k_q};
      pfm_pkg::REG_TIMEOUT:  prdata = {24'd0, timeout_q};
      default:               prdata = '0;
    endcase
  end

  // The front accepts and queues items; the back runs the arithmetic.
  pfm_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_ch     (in_ch),
    .q_valid_o (q_valid),
    .q_entry_o (q_entry),
    .q_pop_i   (q_pop)
  );

  pfm_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_entry_i (q_entry),
    .q_pop_o   (q_pop),
    .k_i       (k_q),
    .timeout_i (timeout_q),
    .out_ch    (out_ch)
  );

endmodule

// ===== sv/pfm_front.sv =====
module pfm_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  pfm_in_if.sink          in_ch,
  output logic            q_valid_o,
  output pfm_pkg::entry_t q_entry_o,
  input  logic            q_pop_i
);

  pfm_pkg::entry_t mem_q [pfm_pkg::QDEPTH];
  logic [pfm_pkg::QPTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [pfm_pkg::QPTR_W:0]   cnt_q, cnt_d;

  pfm_pkg::entry_t entry;
  logic            is_cmd;
  logic            accept;
  logic            push;
  logic            pop;

  // Classify the item. The unused opcode is accepted and dropped.
  always_comb begin
    entry.elapsed = in_ch.elapsed_us;
    entry.cmd     = pfm_pkg::CMD_PULSE;
    is_cmd        = 1'b1;
    case (in_ch.opcode)
      pfm_pkg::OP_PULSE:  entry.cmd = pfm_pkg::CMD_PULSE;
      pfm_pkg::OP_UPDATE: entry.cmd = pfm_pkg::CMD_UPDATE;
      pfm_pkg::OP_CLEAR:  entry.cmd = pfm_pkg::CMD_CLEAR;
      default:            is_cmd    = 1'b0;
    endcase
  end

  assign in_ch.ready = (cnt_q != (pfm_pkg::QPTR_W + 1)'(pfm_pkg::QDEPTH));
  assign accept      = in_ch.valid && in_ch.ready;
  assign push        = accept && is_cmd;
  assign pop         = q_pop_i && (cnt_q != '0);

  assign q_valid_o = (cnt_q != '0);
  assign q_entry_o = mem_q[rd_q];

  always_comb begin
    wr_d  = push ? wr_q + pfm_pkg::QPTR_W'(1) : wr_q;
    rd_d  = pop  ? rd_q + pfm_pkg::QPTR_W'(1) : rd_q;
    cnt_d = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + (pfm_pkg::QPTR_W + 1)'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - (pfm_pkg::QPTR_W + 1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= entry;
    end
  end

endmodule

// ===== sv/pfm_div.sv =====
module pfm_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pfm_pkg::div_req_t req_i,
  output pfm_pkg::div_res_t res_o
);

  logic                        busy_q, done_q;
  logic [pfm_pkg::STEP_W-1:0]  cnt_q;
  logic [pfm_pkg::DEN_W-1:0]   rem_q, den_q;
  logic [pfm_pkg::QUOT_W-1:0]  bits_q, quot_q;
  logic                        ovf_q;

  logic [pfm_pkg::DEN_W-1:0]   init_rem;
  logic [pfm_pkg::DEN_W:0]     trial;
  logic [pfm_pkg::DEN_W:0]     diff;
  logic                        ge;
  logic                        last_step;

  // The quotient is known to need at most 16 or 32 bits unless the initial
  // remainder already reaches the divisor, which flags an overflow.
  assign init_rem = req_i.long_run ? {16'd0, req_i.num[55:32]} : req_i.num[55:16];

  assign trial     = {rem_q, bits_q[pfm_pkg::QUOT_W-1]};
  assign ge        = (trial >= {1'b0, den_q});
  assign diff      = trial - {1'b0, den_q};
  assign last_step = busy_q && (cnt_q == pfm_pkg::STEP_W'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= last_step;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= req_i.long_run ? pfm_pkg::VOL_STEPS : pfm_pkg::FLOW_STEPS;
      end else if (busy_q) begin
        cnt_q <= cnt_q - pfm_pkg::STEP_W'(1);
        if (last_step) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q  <= init_rem;
      den_q  <= req_i.den;
      bits_q <= req_i.long_run ? req_i.num[31:0] : {req_i.num[15:0], 16'd0};
      quot_q <= '0;
      ovf_q  <= (init_rem >= req_i.den);
    end else if (busy_q) begin
      rem_q  <= ge ? diff[pfm_pkg::DEN_W-1:0] : trial[pfm_pkg::DEN_W-1:0];
      bits_q <= {bits_q[pfm_pkg::QUOT_W-2:0], 1'b0};
      quot_q <= {quot_q[pfm_pkg::QUOT_W-2:0], ge};
    end
  end

  assign res_o.done = done_q;
  assign res_o.ovf  = ovf_q;
  assign res_o.quot = quot_q;

endmodule

// ===== sv/pfm_back.sv =====
module pfm_back (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            q_valid_i,
  input  pfm_pkg::entry_t                 q_entry_i,
  output logic                            q_pop_o,
  input  logic [pfm_pkg::K_W-1:0]         k_i,
  input  logic [pfm_pkg::TIMEOUT_W-1:0]   timeout_i,
  pfm_out_if.source                       out_ch
);

  typedef enum logic [6:0] {
    ST_IDLE      = 7'b0000001,
    ST_MUL       = 7'b0000010,
    ST_FLOW_GO   = 7'b0000100,
    ST_FLOW_WAIT = 7'b0001000,
    ST_VOL_GO    = 7'b0010000,
    ST_VOL_WAIT  = 7'b0100000,
    ST_EMIT      = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  logic [pfm_pkg::PULSE_W-1:0]   interval_q, interval_d;
  logic [pfm_pkg::SESSION_W-1:0] session_q, session_d;
  logic [pfm_pkg::FLOW_W-1:0]    flow_q, flow_d;
  logic [pfm_pkg::IDLE_W-1:0]    idle_q, idle_d;

  logic [pfm_pkg::PULSE_W-1:0]   pulses_q;
  logic [pfm_pkg::ELAPSED_W-1:0] elapsed_q;
  logic [pfm_pkg::NUM_W-1:0]     fnum_q;
  logic [pfm_pkg::DEN_W-1:0]     fden_q;
  logic [pfm_pkg::VNUM_W-1:0]    vnum_q;
  logic [pfm_pkg::VOL_W-1:0]     vol_q;

  logic                          out_valid_q;
  logic [pfm_pkg::FLOW_W-1:0]    out_flow_q;
  logic [pfm_pkg::VOL_W-1:0]     out_vol_q;
  logic [pfm_pkg::PULSE_W-1:0]   out_pulses_q;
  logic [pfm_pkg::IDLE_W-1:0]    out_idle_q;
  logic                          out_nosig_q;

  logic [pfm_pkg::SESSION_W:0]   sum;
  logic                          take_update;
  logic                          load_out;

  pfm_pkg::div_req_t div_req;
  pfm_pkg::div_res_t div_res;

  pfm_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .res_o  (div_res)
  );

  assign q_pop_o     = (state_q == ST_IDLE) && q_valid_i;
  assign take_update = q_pop_o && (q_entry_i.cmd == pfm_pkg::CMD_UPDATE);
  assign load_out    = (state_q == ST_EMIT) && (!out_valid_q || out_ch.ready);
  assign sum         = {1'b0, session_q} + {17'd0, interval_q};

  always_comb begin
    div_req.start    = (state_q == ST_FLOW_GO) || (state_q == ST_VOL_GO);
    div_req.long_run = (state_q == ST_VOL_GO);
    div_req.num      = (state_q == ST_FLOW_GO) ? fnum_q : {7'd0, vnum_q};
    div_req.den      = (state_q == ST_FLOW_GO) ? fden_q : {24'd0, k_i};
  end

  always_comb begin
    state_d    = state_q;
    interval_d = interval_q;
    session_d  = session_q;
    flow_d     = flow_q;
    idle_d     = idle_q;
    case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          case (q_entry_i.cmd)
            pfm_pkg::CMD_PULSE: begin
              if (interval_q != '1) begin
                interval_d = interval_q + pfm_pkg::PULSE_W'(1);
              end
            end
            pfm_pkg::CMD_CLEAR: begin
              session_d = '0;
            end
            pfm_pkg::CMD_UPDATE: begin
              interval_d = '0;
              session_d  = sum[pfm_pkg::SESSION_W] ? '1 : sum[pfm_pkg::SESSION_W-1:0];
              if (interval_q == '0) begin
                if (idle_q != '1) begin
                  idle_d = idle_q + pfm_pkg::IDLE_W'(1);
                end
              end else begin
                idle_d = '0;
              end
              state_d = ST_MUL;
            end
            default: begin
            end
          endcase
        end
      end
      ST_MUL: begin
        // With no elapsed time the previous flow is kept.
        state_d = (elapsed_q == '0) ? ST_VOL_GO : ST_FLOW_GO;
      end
      ST_FLOW_GO: begin
        state_d = ST_FLOW_WAIT;
      end
      ST_FLOW_WAIT: begin
        if (div_res.done) begin
          flow_d  = div_res.ovf ? '1 : div_res.quot[pfm_pkg::FLOW_W-1:0];
          state_d = ST_VOL_GO;
        end
      end
      ST_VOL_GO: begin
        state_d = ST_VOL_WAIT;
      end
      ST_VOL_WAIT: begin
        if (div_res.done) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (load_out) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      interval_q  <= '0;
      session_q   <= '0;
      flow_q      <= '0;
      idle_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      interval_q <= interval_d;
      session_q  <= session_d;
      flow_q     <= flow_d;
      idle_q     <= idle_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_update) begin
      pulses_q  <= interval_q;
      elapsed_q <= q_entry_i.elapsed;
    end
    if (state_q == ST_MUL) begin
      fnum_q <= {40'd0, pulses_q} * {16'd0, pfm_pkg::FLOW_SCALE};
      fden_q <= {16'd0, elapsed_q} * {24'd0, k_i};
      vnum_q <= {17'd0, session_q} * {32'd0, pfm_pkg::VOL_SCALE};
    end
    if ((state_q == ST_VOL_WAIT) && div_res.done) begin
      vol_q <= div_res.ovf ? '1 : div_res.quot;
    end
    if (load_out) begin
      out_flow_q   <= flow_q;
      out_vol_q    <= vol_q;
      out_pulses_q <= pulses_q;
      out_idle_q   <= idle_q;
      out_nosig_q  <= (idle_q > timeout_i);
    end
  end

  assign out_ch.valid           = out_valid_q;
  assign out_ch.flow_centi_lpm  = out_flow_q;
  assign out_ch.volume_ml       = out_vol_q;
  assign out_ch.interval_pulses = out_pulses_q;
  assign out_ch.idle_updates    = out_idle_q;
  assign out_ch.no_signal       = out_nosig_q;

endmodule
